>>> src/trar_pkg.sv
// ----------------------------------------------------------------------------
// trar_pkg - shared types and constants for the true range average ratio core
// Field widths, fixed-point scaling, register map, sequencer states and the
// request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package trar_pkg;

  // Fixed-point layout
  localparam int unsigned PriceWidth    = 32;
  localparam int unsigned RangeFracBits = 16;
  localparam int unsigned RatioFracBits = 24;
  localparam int unsigned AvgWidth      = 48;
  localparam int unsigned PeriodWidth   = 10;
  localparam int unsigned CountWidth    = 11;
  // avg * (period - 1) and the sum with the scaled true range
  localparam int unsigned ProdWidth     = AvgWidth + PeriodWidth;
  localparam int unsigned NumWidth      = ProdWidth + 1;

  // Divider step counts
  localparam int unsigned StepWidth     = $clog2(NumWidth + 1);
  localparam logic [StepWidth-1:0] AvgSteps   = StepWidth'(NumWidth);
  localparam logic [StepWidth-1:0] RatioSteps = StepWidth'(RatioFracBits);

  // Register map: one 32-bit register at byte address 0
  localparam int unsigned AddrWidth     = 3;
  localparam int unsigned DataWidth     = 32;
  localparam logic [0:0]  RegPeriod     = 1'b0;
  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(14);

  typedef struct packed {
    logic [PriceWidth-1:0] bar_high;
    logic [PriceWidth-1:0] bar_low;
    logic [PriceWidth-1:0] bar_close;
  } bar_t;

  typedef struct packed {
    logic [RatioFracBits-1:0] range_ratio;
    logic [AvgWidth-1:0]      average_range;
    logic                     ratio_valid;
  } result_t;

  // Divider request: remainder preload, dividend bits (MSB first), divisor
  typedef struct packed {
    logic                 start;
    logic [AvgWidth-1:0]  rem_init;
    logic [NumWidth-1:0]  dividend;
    logic [AvgWidth-1:0]  divisor;
    logic [StepWidth-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [AvgWidth-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StTrHl,
    StTrHp,
    StTrLp,
    StMul,
    StAdd,
    StDivAvg,
    StRatio,
    StDivRatio,
    StDone
  } state_e;

endpackage : trar_pkg

`default_nettype wire

>>> src/trar_div.sv
// ----------------------------------------------------------------------------
// trar_div - shared restoring divider, one quotient bit per cycle
// Remainder is preloaded, dividend bits shift in MSB first; the low AvgWidth
// quotient bits are kept. done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module trar_div
  import trar_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepWidth-1:0] cnt_q, cnt_d;
  logic [AvgWidth-1:0]  rem_q, rem_d;
  logic [NumWidth-1:0]  dvd_q, dvd_d;
  logic [AvgWidth-1:0]  den_q, den_d;
  logic [AvgWidth-1:0]  quot_q, quot_d;

  logic [AvgWidth:0]    trial;
  logic [AvgWidth:0]    diff;
  logic                 fits;

  // One trial subtraction per cycle
  assign trial = {rem_q, dvd_q[NumWidth-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    quot_d = quot_q;
    done_d = busy_q && (cnt_q == StepWidth'(1));
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      dvd_d  = req_i.dividend;
      den_d  = req_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits AvgWidth bits
      rem_d  = fits ? diff[AvgWidth-1:0] : trial[AvgWidth-1:0];
      quot_d = {quot_q[AvgWidth-2:0], fits};
      dvd_d  = {dvd_q[NumWidth-2:0], 1'b0};
      cnt_d  = cnt_q - StepWidth'(1);
      if (cnt_q == StepWidth'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule : trar_div

`default_nettype wire

>>> src/true_range_average_ratio_core.sv
// ----------------------------------------------------------------------------
// true_range_average_ratio_core - Wilder average true range over close
// Per bar: true range, cumulative mean then Wilder smoothing of the range,
// and the average over the close as a saturated Q0.24 fraction.
// ----------------------------------------------------------------------------
// Sequence: a bar runs through the true-range steps, the multiply and the add, the
//   average division in the shared divider, then the ratio division; the ratio
//   division is skipped when the ratio saturates or the close is zero, and the
//   first bar after reset goes straight to the result.
// Flow: one bar at a time; in_ready_o is high only when idle.
// Reset: asynchronous, active low; clears history and sets the period to 14.
`default_nettype none

module true_range_average_ratio_core
  import trar_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input bars
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bar_t                 in_data_i,
  // results
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output result_t                   out_data_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0]      prdata,
  output logic                      pready
);

  state_e                   state_q, state_d;
  logic [PeriodWidth-1:0]   period_q;
  logic [CountWidth-1:0]    bars_q, bars_d;
  logic [PriceWidth-1:0]    prev_q, prev_d;
  logic [AvgWidth-1:0]      avg_q, avg_d;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_q, out_d;

  bar_t                     bar_q, bar_d;
  logic [PriceWidth-1:0]    tr_q, tr_d;
  logic [ProdWidth-1:0]     prod_q, prod_d;
  logic [RatioFracBits-1:0] ratio_q, ratio_d;
  logic                     rvalid_q, rvalid_d;

  logic                     in_fire;
  logic                     out_free;
  logic                     cfg_wr;

  logic [PeriodWidth-1:0]   per_eff;
  logic [CountWidth-1:0]    div_n;
  logic [PeriodWidth-1:0]   div_nm1;
  logic [AvgWidth-1:0]      tr_scaled;
  logic [AvgWidth-1:0]      close_den;

  logic [PriceWidth-1:0]    opa, opb;
  logic                     op_ge;
  logic [PriceWidth-1:0]    op_abs;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Handshakes
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrWidth-1:2] == RegPeriod);
  assign prdata = (paddr[AddrWidth-1:2] == RegPeriod) ?
                  DataWidth'(period_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_wr) begin
      period_q <= pwdata[PeriodWidth-1:0];
    end
  end

  // Divisor: bar count while averaging up, then the period (zero acts as one)
  assign per_eff   = (period_q == '0) ? PeriodWidth'(1) : period_q;
  assign div_n     = (bars_q <= {1'b0, per_eff}) ? bars_q : {1'b0, per_eff};
  assign div_nm1   = div_n[PeriodWidth-1:0] - PeriodWidth'(1);
  assign tr_scaled = {tr_q, {RangeFracBits{1'b0}}};
  assign close_den = {bar_q.bar_close, {RangeFracBits{1'b0}}};

  // Shared absolute-difference unit for the three range terms
  always_comb begin
    case (state_q)
      StTrHl:  begin opa = bar_q.bar_high; opb = bar_q.bar_low; end
      StTrHp:  begin opa = bar_q.bar_high; opb = prev_q;        end
      default: begin opa = bar_q.bar_low;  opb = prev_q;        end
    endcase
  end
  assign op_ge  = opa >= opb;
  assign op_abs = op_ge ? (opa - opb) : (opb - opa);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = (bars_q == '0) ? StDone : StTrHl;
        end
      end
      StTrHl:   state_d = StTrHp;
      StTrHp:   state_d = StTrLp;
      StTrLp:   state_d = StMul;
      StMul:    state_d = StAdd;
      StAdd:    state_d = StDivAvg;
      StDivAvg: begin
        if (div_rsp.done) begin
          state_d = StRatio;
        end
      end
      StRatio: begin
        if (bar_q.bar_close != '0 && avg_q < close_den) begin
          state_d = StDivRatio;
        end else begin
          state_d = StDone;
        end
      end
      StDivRatio: begin
        if (div_rsp.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    bar_d       = bar_q;
    tr_d        = tr_q;
    prod_d      = prod_q;
    ratio_d     = ratio_q;
    rvalid_d    = rvalid_q;
    bars_d      = bars_q;
    prev_d      = prev_q;
    avg_d       = avg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_req     = '0;
    unique case (state_q) inside
      StIdle: begin
        if (in_fire) begin
          bar_d    = in_data_i;
          ratio_d  = '0;
          rvalid_d = 1'b0;
          if (bars_q == '0) begin
            bars_d = CountWidth'(1);
          end
        end
      end
      StTrHl: begin
        // high below low counts as zero
        tr_d = op_ge ? op_abs : '0;
      end
      StTrHp, StTrLp: begin
        if (op_abs > tr_q) begin
          tr_d = op_abs;
        end
      end
      StMul: begin
        prod_d = ProdWidth'(avg_q) * ProdWidth'(div_nm1);
      end
      StAdd: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = NumWidth'(prod_q) + NumWidth'(tr_scaled);
        div_req.divisor  = AvgWidth'(div_n);
        div_req.steps    = AvgSteps;
      end
      StDivAvg: begin
        if (div_rsp.done) begin
          avg_d = div_rsp.quotient;
          if (bars_q <= {1'b0, per_eff}) begin
            bars_d = bars_q + CountWidth'(1);
          end
        end
      end
      StRatio: begin
        if (bar_q.bar_close != '0) begin
          rvalid_d = 1'b1;
          if (avg_q >= close_den) begin
            ratio_d = {RatioFracBits{1'b1}};
          end else begin
            div_req.start    = 1'b1;
            div_req.rem_init = avg_q;
            div_req.dividend = '0;
            div_req.divisor  = close_den;
            div_req.steps    = RatioSteps;
          end
        end
      end
      StDivRatio: begin
        if (div_rsp.done) begin
          ratio_d = div_rsp.quotient[RatioFracBits-1:0];
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.range_ratio   = ratio_q;
          out_d.average_range = avg_q;
          out_d.ratio_valid   = rvalid_q;
          prev_d              = bar_q.bar_close;
        end
      end
      default: ;
    endcase
  end

  // Control and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bars_q      <= '0;
      prev_q      <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bars_q      <= bars_d;
      prev_q      <= prev_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bar_q    <= bar_d;
    tr_q     <= tr_d;
    prod_q   <= prod_d;
    ratio_q  <= ratio_d;
    rvalid_q <= rvalid_d;
    out_q    <= out_d;
  end

  trar_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : true_range_average_ratio_core

`default_nettype wire

>>> src/trar_checker.sv
// ----------------------------------------------------------------------------
// trar_checker - port-level assertions for the true range average ratio core
// Watches the result channel and the input handshake over time.
// ----------------------------------------------------------------------------
`default_nettype none

module trar_checker
  import trar_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_ready_o,
  input wire logic    out_valid_o,
  input wire logic    out_ready_i,
  input wire result_t out_data_o
);

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // One bar at a time: ready drops after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a bar is in flight");

  // No ratio without a valid flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ratio_valid |-> out_data_o.range_ratio == '0)
    else $error("nonzero ratio on an invalid result");

endmodule : trar_checker

bind true_range_average_ratio_core trar_checker u_trar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> verif/atr_ratio_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atr_ratio_checker - scoreboard for the true range average ratio core
// Watches the configuration port and both beat channels, keeps its own copy
// of the period, bar count, previous close and smoothed range, predicts each
// result beat and compares it field by field in arrival order.
// ----------------------------------------------------------------------------

module atr_ratio_checker
  import trar_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // bar channel
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  bar_t                 in_data_i,
  // result channel
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  result_t              out_data_i,
  // configuration port
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [AddrWidth-1:0] paddr_i,
  input  logic [DataWidth-1:0] pwdata_i,
  // status to the test
  output int unsigned          fail_count_o,
  output int unsigned          results_pending_o
);

  localparam logic [AddrWidth-1:0] PeriodAddr = AddrWidth'(4 * RegPeriod);

  // Mirrored block state
  logic [PeriodWidth-1:0] period      = PeriodReset;
  logic [CountWidth-1:0]  bars_seen   = '0;
  logic [PriceWidth-1:0]  prev_close  = '0;
  logic [AvgWidth-1:0]    avg_range   = '0;

  result_t     expected_results [$];
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;

  function automatic logic [PriceWidth-1:0] abs_distance(input logic [PriceWidth-1:0] a,
                                                         input logic [PriceWidth-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the mirrored average by one bar and return the result it causes
  function automatic result_t advance_average(input bar_t bar);
    logic [CountWidth-1:0] eff_period;
    logic [PriceWidth-1:0] true_range;
    logic [PriceWidth-1:0] distance;
    logic [63:0]           numer;
    logic [AvgWidth-1:0]   close_scaled;
    logic [71:0]           avg_shifted;
    result_t               res;
    res = '0;
    eff_period = (period == '0) ? CountWidth'(1) : CountWidth'(period);
    if (bars_seen == '0) begin
      // first bar only seeds the previous close
      bars_seen = CountWidth'(1);
    end else begin
      true_range = (bar.bar_high >= bar.bar_low) ? bar.bar_high - bar.bar_low : '0;
      distance = abs_distance(bar.bar_high, prev_close);
      if (distance > true_range) true_range = distance;
      distance = abs_distance(bar.bar_low, prev_close);
      if (distance > true_range) true_range = distance;

      if (bars_seen <= eff_period) begin
        // cumulative mean while filling up
        numer = 64'(avg_range) * (64'(bars_seen) - 64'd1)
              + (64'(true_range) << RangeFracBits);
        avg_range = AvgWidth'(numer / 64'(bars_seen));
        bars_seen = bars_seen + CountWidth'(1);
      end else begin
        // Wilder smoothing
        numer = 64'(avg_range) * (64'(eff_period) - 64'd1)
              + (64'(true_range) << RangeFracBits);
        avg_range = AvgWidth'(numer / 64'(eff_period));
      end

      if (bar.bar_close != '0) begin
        close_scaled = {bar.bar_close, {RangeFracBits{1'b0}}};
        if (avg_range >= close_scaled) begin
          res.range_ratio = '1;
        end else begin
          avg_shifted = {avg_range, {RatioFracBits{1'b0}}};
          res.range_ratio = RatioFracBits'(avg_shifted / 72'(close_scaled));
        end
        res.ratio_valid = 1'b1;
      end
    end
    prev_close = bar.bar_close;
    res.average_range = avg_range;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [AvgWidth-1:0] want_v,
                               input logic [AvgWidth-1:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: result beat %0d: %s expected 0x%0h got 0x%0h",
               $time, results_seen, what, want_v, got_v);
    end
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    result_t predicted;
    if (!rst_ni) begin
      period     = PeriodReset;
      bars_seen  = '0;
      prev_close = '0;
      avg_range  = '0;
      expected_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == PeriodAddr) begin
        period = pwdata_i[PeriodWidth-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        predicted = advance_average(in_data_i);
        expected_results = {expected_results, predicted};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("beat with nothing expected, average_range", '0,
                        out_data_i.average_range);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.range_ratio !== want.range_ratio)
            flag_mismatch("range_ratio", AvgWidth'(want.range_ratio),
                          AvgWidth'(out_data_i.range_ratio));
          if (out_data_i.average_range !== want.average_range)
            flag_mismatch("average_range", want.average_range, out_data_i.average_range);
          if (out_data_i.ratio_valid !== want.ratio_valid)
            flag_mismatch("ratio_valid", AvgWidth'(want.ratio_valid),
                          AvgWidth'(out_data_i.ratio_valid));
        end
        results_seen++;
      end
    end
    fail_count_o      <= mismatches;
    results_pending_o <= expected_results.size();
  end

endmodule : atr_ratio_checker

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - stimulus for the true range average ratio core
// Drives price bars through a directed edge-case run and then random phases,
// each opening with a write of the smoothing period, with random gaps on both beat
// channels, long output hold-offs and drain pauses; the checker judges.
// ----------------------------------------------------------------------------

module testbench;
  import trar_pkg::*;

  localparam logic [AddrWidth-1:0] PeriodAddr = AddrWidth'(4 * RegPeriod);
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned PhaseBars   = 90;
  localparam int unsigned HoldCycles  = 400;

  // Fixed periods for the first phases, random after that
  localparam int unsigned PhasePeriods [9] = '{1, 1023, 3, 0, 2, 14, 1023, 1, 512};

  // Edge bars: first bar, zero close, saturation, high below low, extremes
  localparam bar_t EdgeBars [8] = '{
    '{32'd100,        32'd90,         32'd95},
    '{32'd110,        32'd100,        32'd105},
    '{32'd0,          32'd0,          32'd0},
    '{32'hFFFF_FFFF,  32'd0,          32'd1},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
    '{32'd0,          32'hFFFF_FFFF,  32'd0},
    '{32'd5,          32'd10,         32'd7},
    '{32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  bar_t                 in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  result_t              out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrWidth-1:0] paddr       = '0;
  logic [DataWidth-1:0] pwdata      = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  int unsigned check_failures;
  int unsigned results_pending;

  longint      price_level   = 1000;
  logic        sender_quiet  = 1'b0;
  int unsigned hold_requests = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  true_range_average_ratio_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  atr_ratio_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i        (in_ready_o),
    .in_data_i,
    .out_valid_i       (out_valid_o),
    .out_ready_i,
    .out_data_i        (out_data_o),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .fail_count_o      (check_failures),
    .results_pending_o (results_pending)
  );

  function automatic logic [PriceWidth-1:0] clamp_price(input longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hFFFF_FFFF)) return '1;
    return PriceWidth'(v);
  endfunction

  function automatic logic [PriceWidth-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return PriceWidth'(1);
      2: return '1;
      3: return {{(PriceWidth-1){1'b1}}, 1'b0};
      default: return $urandom;
    endcase
  endfunction

  // Mostly plausible bars drifting around a price level, plus noise
  function automatic bar_t make_bar();
    bar_t        b;
    longint      span;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick >= 70 && pick < 85) begin
      b = {$urandom, $urandom, $urandom};
    end else if (pick >= 85 && pick < 95) begin
      b = {pick_extreme(), pick_extreme(), pick_extreme()};
    end else begin
      span = (price_level >> $urandom_range(3, 9)) + 1;
      price_level = clamp_price(price_level + longint'($urandom_range(0, 32'(2 * span)))
                                - span);
      b.bar_high  = clamp_price(price_level + longint'($urandom_range(0, 32'(span))));
      b.bar_low   = clamp_price(price_level - longint'($urandom_range(0, 32'(span))));
      b.bar_close = b.bar_low + PriceWidth'($urandom_range(0, 32'(b.bar_high - b.bar_low)));
      if (pick >= 95) b.bar_close = '0;
    end
    return b;
  endfunction

  task automatic send_bar(input bar_t bar);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= bar;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering bars until every predicted result has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic write_period(input logic [DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PeriodAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls in bursts, quiet bursts, and long hold-offs
  initial begin
    int unsigned stall;
    int unsigned burst_left;
    int unsigned holds_done;
    logic        quiet;
    burst_left = 0;
    holds_done = 0;
    quiet      = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 40);
        quiet      = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Bar side and verdict
  initial begin
    logic [DataWidth-1:0] word;
    int unsigned          period_val;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed run under the reset period, long enough to reach smoothing
    foreach (EdgeBars[k]) send_bar(EdgeBars[k]);
    repeat (12) send_bar(make_bar());

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      period_val = (ph < 9) ? PhasePeriods[ph] : $urandom_range(0, 1023);
      word = $urandom;
      word[PeriodWidth-1:0] = PeriodWidth'(period_val);
      write_period(word);
      price_level  = (longint'($urandom_range(16, 32'hFFFF_FFFF)) >> $urandom_range(0, 24))
                   + 1;
      sender_quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseBars; n++) begin
        // back up the output while bars keep coming
        if (n == 30 && (ph == 2 || ph == 7)) hold_requests <= hold_requests + 1;
        if ($urandom_range(0, 24) == 0) wait_drained();
        send_bar(make_bar());
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (check_failures == 0 && results_pending == 0) begin
      $display("true_range_average_ratio_core verification clean");
    end else begin
      $display("true_range_average_ratio_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("true_range_average_ratio_core verification failed");
    $finish;
  end

endmodule : testbench
